### design/bpsc_pkg.sv
package bpsc_pkg;

    // Countdown width; timeout registers are truncated or zero-extended to it.
    localparam int TIMEOUT_BITS = 16;

    localparam int CHARGE_W   = 32;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    typedef enum logic [2:0] {
        MODE_GOOD = 3'd0,
        MODE_LOW  = 3'd1,
        MODE_CRIT = 3'd2,
        MODE_PLUG = 3'd3,
        MODE_STBY = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THRESHOLD  = 3'd0,
        CFG_RECOVERY_MODE  = 3'd1,
        CFG_RECOVERY_THRES = 3'd2,
        CFG_FIRST_TIMEOUT  = 3'd3,
        CFG_RUN_TIMEOUT    = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        REQ_EVENT = 1'b0,
        REQ_TICK  = 1'b1
    } req_t;

    localparam logic [CHARGE_W-1:0]  LOW_THRESHOLD_RST  = 32'd429496729;
    localparam logic [CHARGE_W-1:0]  RECOVERY_THRES_RST = 32'd214748364;
    localparam logic [TIMEOUT_W-1:0] FIRST_TIMEOUT_RST  = 16'd2000;
    localparam logic [TIMEOUT_W-1:0] RUN_TIMEOUT_RST    = 16'd30000;

    typedef struct packed {
        logic [CHARGE_W-1:0]  low_threshold_ratio;
        logic                 recovery_mode;
        logic [CHARGE_W-1:0]  recovery_threshold_ratio;
        logic [TIMEOUT_W-1:0] first_run_timeout;
        logic [TIMEOUT_W-1:0] running_timeout;
    } cfg_t;

    typedef struct packed {
        req_t                req_type;
        logic [CHARGE_W-1:0] charge_ratio;
        logic                charging;
        logic                ext_power;
        logic                update_in_progress;
    } item_t;

    typedef struct packed {
        mode_t                   mode;
        logic                    first_event;
        logic                    low_at_start;
        logic [TIMEOUT_BITS-1:0] countdown;
        logic                    countdown_armed;
    } state_t;

    typedef struct packed {
        logic  timeout_running;
        logic  critical_lockout;
        logic  standby_request;
        logic  resume_normal;
        logic  enter_low_power;
        mode_t mode_now;
    } result_t;

endpackage

### design/bpsc_step.sv
// Next state and result for one request, purely combinational.
module bpsc_step (
    input  bpsc_pkg::cfg_t    cfg,
    input  bpsc_pkg::state_t  cur,
    input  bpsc_pkg::item_t   item,
    output bpsc_pkg::state_t  nxt,
    output bpsc_pkg::result_t res
);

    logic                 critical;
    logic                 low;
    logic                 las;
    bpsc_pkg::mode_t      target;
    logic                 do_change;
    logic                 p_enter_low;
    logic                 p_resume;
    logic                 p_standby;
    logic [bpsc_pkg::TIMEOUT_BITS-1:0] load_value;

    always_comb begin
        critical = (item.charge_ratio == '0) && !item.charging;
        if (cfg.recovery_mode) begin
            low = item.charge_ratio < cfg.recovery_threshold_ratio;
            las = 1'b0;
        end else begin
            low = !item.charging && (item.charge_ratio <= cfg.low_threshold_ratio);
            if (low && cur.first_event && !item.ext_power) begin
                las = 1'b1;
            end else if (!low) begin
                las = 1'b0;
            end else begin
                las = cur.low_at_start;
            end
        end

        load_value = cur.first_event
            ? bpsc_pkg::TIMEOUT_BITS'(cfg.first_run_timeout)
            : bpsc_pkg::TIMEOUT_BITS'(cfg.running_timeout);

        nxt       = cur;
        target    = cur.mode;
        do_change = 1'b0;

        if (item.req_type == bpsc_pkg::REQ_TICK) begin
            if (cur.countdown_armed) begin
                if (cur.countdown <= bpsc_pkg::TIMEOUT_BITS'(1)) begin
                    nxt.countdown       = '0;
                    nxt.countdown_armed = 1'b0;
                    if (cur.mode == bpsc_pkg::MODE_CRIT) begin
                        target    = bpsc_pkg::MODE_STBY;
                        do_change = 1'b1;
                    end
                end else begin
                    nxt.countdown = cur.countdown - bpsc_pkg::TIMEOUT_BITS'(1);
                end
            end
        end else begin
            nxt.low_at_start = las;
            nxt.first_event  = 1'b0;
            if (item.ext_power) begin
                target = bpsc_pkg::MODE_PLUG;
            end else if (critical || las) begin
                target = bpsc_pkg::MODE_CRIT;
            end else if (low) begin
                target = bpsc_pkg::MODE_LOW;
            end else begin
                target = bpsc_pkg::MODE_GOOD;
            end
            do_change = 1'b1;
        end

        p_enter_low = 1'b0;
        p_resume    = 1'b0;
        p_standby   = 1'b0;
        if (do_change && (target != cur.mode)) begin
            nxt.mode = target;
            // exit side of the old mode
            if (cur.mode == bpsc_pkg::MODE_CRIT) begin
                nxt.countdown       = '0;
                nxt.countdown_armed = 1'b0;
            end
            if ((cur.mode == bpsc_pkg::MODE_LOW || cur.mode == bpsc_pkg::MODE_CRIT) &&
                (target == bpsc_pkg::MODE_GOOD || target == bpsc_pkg::MODE_PLUG)) begin
                p_resume = 1'b1;
            end
            // entry side of the new mode
            case (target)
                bpsc_pkg::MODE_LOW: begin
                    p_enter_low = !item.update_in_progress;
                end
                bpsc_pkg::MODE_CRIT: begin
                    nxt.countdown       = load_value;
                    nxt.countdown_armed = 1'b1;
                end
                bpsc_pkg::MODE_STBY: begin
                    p_standby = 1'b1;
                end
                default: begin
                end
            endcase
        end

        res.mode_now         = nxt.mode;
        res.enter_low_power  = p_enter_low;
        res.resume_normal    = p_resume;
        res.standby_request  = p_standby;
        res.critical_lockout = (nxt.mode == bpsc_pkg::MODE_CRIT);
        res.timeout_running  = nxt.countdown_armed;
    end

endmodule

### design/battery_power_state_controller.sv
// Battery power-mode controller.
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle unless stalled; mode/countdown state updates in the same
//   cycle the request leaves the input register, so back-to-back requests chain correctly.
// Reset (aresetn low, synchronous): mode good, first event pending, countdown disarmed,
//   config registers to their defaults, both pipeline stages empty, no request taken.
module battery_power_state_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bpsc_pkg::S_TDATA_W-1:0]      s_tdata,  // charge_ratio[31:0], charging[32],
                                                          // ext_power[33],
                                                          // update_in_progress[34], zero pad
    input  logic                                s_tuser,  // req_type: 0 event, 1 tick
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bpsc_pkg::M_TDATA_W-1:0]      m_tdata,  // mode_now[2:0], enter_low_power[3],
                                                          // resume_normal[4],
                                                          // standby_request[5],
                                                          // critical_lockout[6],
                                                          // timeout_running[7]
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bpsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // ---------------- configuration registers ----------------
    bpsc_pkg::cfg_t cfg_reg;

    // writes are dropped while in reset, so do not advertise them
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_threshold_ratio      <= bpsc_pkg::LOW_THRESHOLD_RST;
            cfg_reg.recovery_mode            <= 1'b0;
            cfg_reg.recovery_threshold_ratio <= bpsc_pkg::RECOVERY_THRES_RST;
            cfg_reg.first_run_timeout        <= bpsc_pkg::FIRST_TIMEOUT_RST;
            cfg_reg.running_timeout          <= bpsc_pkg::RUN_TIMEOUT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (bpsc_pkg::cfg_idx_t'(cfg_index))
                bpsc_pkg::CFG_LOW_THRESHOLD: begin
                    cfg_reg.low_threshold_ratio <= cfg_data;
                end
                bpsc_pkg::CFG_RECOVERY_MODE: begin
                    cfg_reg.recovery_mode <= cfg_data[0];
                end
                bpsc_pkg::CFG_RECOVERY_THRES: begin
                    cfg_reg.recovery_threshold_ratio <= cfg_data;
                end
                bpsc_pkg::CFG_FIRST_TIMEOUT: begin
                    cfg_reg.first_run_timeout <= cfg_data[bpsc_pkg::TIMEOUT_W-1:0];
                end
                bpsc_pkg::CFG_RUN_TIMEOUT: begin
                    cfg_reg.running_timeout <= cfg_data[bpsc_pkg::TIMEOUT_W-1:0];
                end
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    // ---------------- input register ----------------
    logic            in_valid_reg;
    bpsc_pkg::item_t in_item_reg;
    logic            out_valid_reg;
    bpsc_pkg::result_t out_res_reg;

    // stage 2 fires when it holds a request and the result slot is free or draining
    logic advance;
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = aresetn && (!in_valid_reg || advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.req_type           <= bpsc_pkg::req_t'(s_tuser);
            in_item_reg.charge_ratio       <= s_tdata[bpsc_pkg::CHARGE_W-1:0];
            in_item_reg.charging           <= s_tdata[bpsc_pkg::CHARGE_W];
            in_item_reg.ext_power          <= s_tdata[bpsc_pkg::CHARGE_W+1];
            in_item_reg.update_in_progress <= s_tdata[bpsc_pkg::CHARGE_W+2];
        end
    end

    // ---------------- controller state ----------------
    bpsc_pkg::state_t  state_reg;
    bpsc_pkg::state_t  state_next;
    bpsc_pkg::result_t res_next;

    bpsc_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (in_item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode            <= bpsc_pkg::MODE_GOOD;
            state_reg.first_event     <= 1'b1;
            state_reg.low_at_start    <= 1'b0;
            state_reg.countdown       <= '0;
            state_reg.countdown_armed <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;

endmodule

### tb/sv/tb_battery_power_state_controller.sv
module tb_battery_power_state_controller;
    timeunit 1ns;
    timeprecision 1ps;

    // Run shape
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 170;   // ~1750 requests with the directed table
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the pipe
    localparam int IDLE_PCT     = 22;    // idle cycles per hundred on each side
    localparam int DRAIN_CYCLES = 4;     // two-stage pipe, plus margin
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } row_kind_t;

    // One line of the directed table: either a request or a register write.
    // Where has_exp is set the result is typed in, else the predictor supplies it.
    typedef struct {
        row_kind_t                       kind;
        bpsc_pkg::item_t                 item;
        bpsc_pkg::cfg_idx_t              reg_idx;
        logic [bpsc_pkg::CFG_DATA_W-1:0] reg_val;
        logic                            has_exp;
        bpsc_pkg::result_t               exp;
    } dir_row_t;

    typedef struct {
        logic              has_exp;
        bpsc_pkg::result_t exp;
    } typed_exp_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [bpsc_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                             s_tuser   = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [bpsc_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [bpsc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [bpsc_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predictor copy of the controller
    bpsc_pkg::cfg_t                    pwr_cfg;
    bpsc_pkg::mode_t                   pwr_mode;
    logic                              pwr_first;
    logic                              pwr_low_start;
    logic [bpsc_pkg::TIMEOUT_BITS-1:0] pwr_count;
    logic                              pwr_armed;

    bpsc_pkg::result_t expected_modes[$];   // results still owed by the DUT
    typed_exp_t        typed_q[$];          // per request: typed-in result, if any
    dir_row_t          dir_rows[$];

    int unsigned sent_cnt = 0;       // requests accepted (driver side)
    int unsigned rcvd_cnt = 0;       // results accepted (monitor side)
    int unsigned err_cnt  = 0;
    int unsigned stall_cnt = 0;

    logic no_idle    = 1'b0;         // both sides go full rate while set
    logic hold_token = 1'b0;         // toggled by driver to ask for a hold-off
    logic hold_seen  = 1'b0;
    int unsigned hold_left = 0;

    always #5 aclk = ~aclk;

    battery_power_state_controller u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor: one request in, the result it causes out.
    // ------------------------------------------------------------------
    function automatic bpsc_pkg::result_t predict_power_step(bpsc_pkg::item_t it);
        bpsc_pkg::result_t r;
        bpsc_pkg::mode_t   nxt;
        logic              go;
        logic              low;
        logic              crit;
        r   = '0;
        nxt = bpsc_pkg::MODE_GOOD;
        go  = 1'b0;
        if (it.req_type == bpsc_pkg::REQ_TICK) begin
            // countdown only moves while armed
            if (pwr_armed) begin
                if (pwr_count <= 1) begin
                    pwr_count = '0;
                    pwr_armed = 1'b0;
                    if (pwr_mode == bpsc_pkg::MODE_CRIT) begin
                        nxt = bpsc_pkg::MODE_STBY;
                        go  = 1'b1;
                    end
                end else begin
                    pwr_count = pwr_count - 1'b1;
                end
            end
        end else begin
            crit = (it.charge_ratio == '0) && !it.charging;
            if (pwr_cfg.recovery_mode) begin
                // strict compare, charging flag ignored
                low = it.charge_ratio < pwr_cfg.recovery_threshold_ratio;
                pwr_low_start = 1'b0;
            end else begin
                low = !it.charging && (it.charge_ratio <= pwr_cfg.low_threshold_ratio);
                if (low && pwr_first && !it.ext_power)
                    pwr_low_start = 1'b1;
                else if (!low)
                    pwr_low_start = 1'b0;
            end
            if (it.ext_power)
                nxt = bpsc_pkg::MODE_PLUG;
            else if (crit || pwr_low_start)
                nxt = bpsc_pkg::MODE_CRIT;
            else if (low)
                nxt = bpsc_pkg::MODE_LOW;
            else
                nxt = bpsc_pkg::MODE_GOOD;
            go = 1'b1;
        end

        if (go && nxt != pwr_mode) begin
            // exit actions
            if (pwr_mode == bpsc_pkg::MODE_CRIT) begin
                pwr_armed = 1'b0;
                pwr_count = '0;
            end
            if ((pwr_mode == bpsc_pkg::MODE_LOW || pwr_mode == bpsc_pkg::MODE_CRIT) &&
                (nxt == bpsc_pkg::MODE_GOOD || nxt == bpsc_pkg::MODE_PLUG))
                r.resume_normal = 1'b1;
            // entry actions
            case (nxt)
                bpsc_pkg::MODE_LOW: begin
                    r.enter_low_power = !it.update_in_progress;
                end
                bpsc_pkg::MODE_CRIT: begin
                    pwr_count = pwr_first
                        ? bpsc_pkg::TIMEOUT_BITS'(pwr_cfg.first_run_timeout)
                        : bpsc_pkg::TIMEOUT_BITS'(pwr_cfg.running_timeout);
                    pwr_armed = 1'b1;
                end
                bpsc_pkg::MODE_STBY: begin
                    r.standby_request = 1'b1;
                end
                default: ;
            endcase
            pwr_mode = nxt;
        end
        if (it.req_type == bpsc_pkg::REQ_EVENT)
            pwr_first = 1'b0;

        r.mode_now         = pwr_mode;
        r.critical_lockout = (pwr_mode == bpsc_pkg::MODE_CRIT);
        r.timeout_running  = pwr_armed;
        return r;
    endfunction

    task automatic note_error(string what, bpsc_pkg::result_t want, bpsc_pkg::result_t got);
        err_cnt++;
        if (err_cnt <= 10)
            $display({"[%0t] ERROR %s: exp %h got %h ",
                      "(mode/elp/res/stby/crit/tmo exp %0d%b%b%b%b%b got %0d%b%b%b%b%b)"},
                     $time, what, want, got,
                     want.mode_now, want.enter_low_power, want.resume_normal,
                     want.standby_request, want.critical_lockout, want.timeout_running,
                     got.mode_now, got.enter_low_power, got.resume_normal,
                     got.standby_request, got.critical_lockout, got.timeout_running);
    endtask

    // ------------------------------------------------------------------
    // Monitor: tracks config, predicts on each accepted request, checks
    // each accepted result against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        bpsc_pkg::item_t   it;
        bpsc_pkg::result_t want;
        bpsc_pkg::result_t got;
        typed_exp_t        te;
        if (!aresetn) begin
            pwr_cfg.low_threshold_ratio      <= bpsc_pkg::LOW_THRESHOLD_RST;
            pwr_cfg.recovery_mode            <= 1'b0;
            pwr_cfg.recovery_threshold_ratio <= bpsc_pkg::RECOVERY_THRES_RST;
            pwr_cfg.first_run_timeout        <= bpsc_pkg::FIRST_TIMEOUT_RST;
            pwr_cfg.running_timeout          <= bpsc_pkg::RUN_TIMEOUT_RST;
            pwr_mode      <= bpsc_pkg::MODE_GOOD;
            pwr_first     <= 1'b1;
            pwr_low_start <= 1'b0;
            pwr_count     <= '0;
            pwr_armed     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (bpsc_pkg::cfg_idx_t'(cfg_index))
                    bpsc_pkg::CFG_LOW_THRESHOLD:
                        pwr_cfg.low_threshold_ratio = cfg_data;
                    bpsc_pkg::CFG_RECOVERY_MODE:
                        pwr_cfg.recovery_mode = cfg_data[0];
                    bpsc_pkg::CFG_RECOVERY_THRES:
                        pwr_cfg.recovery_threshold_ratio = cfg_data;
                    bpsc_pkg::CFG_FIRST_TIMEOUT:
                        pwr_cfg.first_run_timeout = cfg_data[bpsc_pkg::TIMEOUT_W-1:0];
                    bpsc_pkg::CFG_RUN_TIMEOUT:
                        pwr_cfg.running_timeout = cfg_data[bpsc_pkg::TIMEOUT_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                rcvd_cnt++;
                got = bpsc_pkg::result_t'(m_tdata);
                if (expected_modes.size() == 0) begin
                    note_error("unexpected result", '0, got);
                end else begin
                    want = expected_modes.pop_front();
                    if (got.mode_now         !== want.mode_now         ||
                        got.enter_low_power  !== want.enter_low_power  ||
                        got.resume_normal    !== want.resume_normal    ||
                        got.standby_request  !== want.standby_request  ||
                        got.critical_lockout !== want.critical_lockout ||
                        got.timeout_running  !== want.timeout_running)
                        note_error("result mismatch", want, got);
                end
            end

            if (s_tvalid && s_tready) begin
                it.req_type           = bpsc_pkg::req_t'(s_tuser);
                it.charge_ratio       = s_tdata[bpsc_pkg::CHARGE_W-1:0];
                it.charging           = s_tdata[32];
                it.ext_power          = s_tdata[33];
                it.update_in_progress = s_tdata[34];
                want = predict_power_step(it);
                te.has_exp = 1'b0;
                te.exp     = '0;
                if (typed_q.size() != 0)
                    te = typed_q.pop_front();
                expected_modes.push_back(te.has_exp ? te.exp : want);
            end
        end
    end

    // Receiver: random backpressure, a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: ends the run if nothing moves for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver helpers. After send_item the caller drives s_tvalid again in
    // the same step (next request, gap, or drop), so no request repeats.
    // ------------------------------------------------------------------
    task automatic send_item(bpsc_pkg::item_t it, logic has_exp, bpsc_pkg::result_t exp);
        typed_exp_t te;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        te.has_exp = has_exp;
        te.exp     = exp;
        typed_q.push_back(te);
        s_tvalid <= 1'b1;
        s_tuser  <= it.req_type;
        s_tdata  <= {5'b0, it.update_in_progress, it.ext_power, it.charging,
                     it.charge_ratio};
        do @(posedge aclk); while (!s_tready);
        sent_cnt++;
    endtask

    // Leaves cfg_valid high; caller lowers it or writes again right away.
    task automatic push_reg(bpsc_pkg::cfg_idx_t idx, logic [bpsc_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (rcvd_cnt != sent_cnt)
            @(posedge aclk);
    endtask

    function automatic dir_row_t ev_row(logic [31:0] charge, logic chg, logic plg, logic upd,
                                        logic has, logic [7:0] e);
        dir_row_t r;
        r.kind                    = ROW_ITEM;
        r.item.req_type           = bpsc_pkg::REQ_EVENT;
        r.item.charge_ratio       = charge;
        r.item.charging           = chg;
        r.item.ext_power          = plg;
        r.item.update_in_progress = upd;
        r.reg_idx                 = bpsc_pkg::CFG_LOW_THRESHOLD;
        r.reg_val                 = '0;
        r.has_exp                 = has;
        r.exp                     = bpsc_pkg::result_t'(e);
        return r;
    endfunction

    function automatic dir_row_t tick_row(logic has, logic [7:0] e);
        dir_row_t r;
        r = ev_row('0, 1'b0, 1'b0, 1'b0, has, e);
        r.item.req_type = bpsc_pkg::REQ_TICK;
        return r;
    endfunction

    function automatic dir_row_t reg_row(bpsc_pkg::cfg_idx_t idx,
                                         logic [bpsc_pkg::CFG_DATA_W-1:0] val);
        dir_row_t r;
        r = ev_row('0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Charge values cluster on zero, full, and around the active threshold.
    function automatic logic [31:0] pick_charge();
        logic [31:0] base;
        base = pwr_cfg.recovery_mode ? pwr_cfg.recovery_threshold_ratio
                                     : pwr_cfg.low_threshold_ratio;
        case ($urandom_range(9))
            0, 1:    return '0;
            2:       return '1;
            3, 4:    return base + 32'($urandom_range(4)) - 32'd2;
            5:       return 32'($urandom_range(1000));
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        bpsc_pkg::item_t                 it;
        int unsigned                     n;
        int unsigned                     burst;
        logic [bpsc_pkg::CFG_DATA_W-1:0] v_low, v_rthr;
        logic [bpsc_pkg::TIMEOUT_W-1:0]  v_first, v_run;
        logic                            v_rec;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table. Typed results use the m_tdata layout:
        // mode[2:0], enter_low[3], resume[4], standby[5], lockout[6], armed[7].
        dir_rows.push_back(ev_row(32'd1000, 0, 0, 0, 1, 8'hC2));       // low on first event
        dir_rows.push_back(ev_row('1, 0, 0, 0, 1, 8'h10));             // leave critical
        dir_rows.push_back(ev_row('0, 0, 0, 0, 1, 8'hC2));             // zero charge
        dir_rows.push_back(tick_row(1, 8'hC2));
        dir_rows.push_back(ev_row('0, 0, 1, 0, 1, 8'h13));             // plugged
        dir_rows.push_back(ev_row('0, 0, 1, 0, 1, 8'h03));             // same mode
        dir_rows.push_back(ev_row(32'd100, 0, 0, 0, 1, 8'h09));
        dir_rows.push_back(ev_row(32'd100, 0, 0, 1, 1, 8'h01));
        dir_rows.push_back(ev_row('1, 0, 0, 0, 1, 8'h10));
        dir_rows.push_back(ev_row(32'd100, 0, 0, 1, 1, 8'h01));        // entry during update
        dir_rows.push_back(tick_row(1, 8'h01));                        // tick, disarmed
        dir_rows.push_back(ev_row('0, 1, 0, 0, 1, 8'h10));             // zero but charging
        dir_rows.push_back(ev_row(bpsc_pkg::LOW_THRESHOLD_RST, 0, 0, 0, 1, 8'h09));
        dir_rows.push_back(ev_row(bpsc_pkg::LOW_THRESHOLD_RST + 1, 0, 0, 0, 1, 8'h10));
        dir_rows.push_back(reg_row(bpsc_pkg::CFG_RUN_TIMEOUT, 32'd2));
        dir_rows.push_back(ev_row('0, 0, 0, 0, 1, 8'hC2));
        dir_rows.push_back(tick_row(1, 8'hC2));
        dir_rows.push_back(tick_row(1, 8'h24));                        // expiry to standby
        dir_rows.push_back(tick_row(1, 8'h04));
        dir_rows.push_back(ev_row('1, 0, 0, 0, 1, 8'h00));             // out of standby
        dir_rows.push_back(reg_row(bpsc_pkg::CFG_RUN_TIMEOUT, 32'd0)); // zero timeout
        dir_rows.push_back(ev_row('0, 0, 0, 0, 1, 8'hC2));
        dir_rows.push_back(tick_row(1, 8'h24));
        dir_rows.push_back(reg_row(bpsc_pkg::CFG_RECOVERY_MODE, 32'd1));
        // strict compare
        dir_rows.push_back(ev_row(bpsc_pkg::RECOVERY_THRES_RST, 0, 0, 0, 1, 8'h00));
        dir_rows.push_back(ev_row(bpsc_pkg::RECOVERY_THRES_RST - 1, 1, 0, 0, 1, 8'h09));
        dir_rows.push_back(reg_row(bpsc_pkg::CFG_LOW_THRESHOLD, '1));
        dir_rows.push_back(reg_row(bpsc_pkg::CFG_RECOVERY_THRES, '1));
        dir_rows.push_back(reg_row(bpsc_pkg::CFG_FIRST_TIMEOUT, 32'hFFFF));
        dir_rows.push_back(ev_row('1, 1, 1, 1, 0, 8'h00));
        dir_rows.push_back(ev_row('1, 0, 0, 0, 0, 8'h00));
        dir_rows.push_back(reg_row(bpsc_pkg::CFG_RECOVERY_MODE, 32'd0));
        dir_rows.push_back(ev_row('1, 0, 0, 0, 0, 8'h00));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                wait_drained();
                push_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
                // a following write drives cfg_valid itself
                if ((i + 1 == dir_rows.size()) || (dir_rows[i + 1].kind != ROW_REG))
                    cfg_valid <= 1'b0;
            end else begin
                send_item(dir_rows[i].item, dir_rows[i].has_exp, dir_rows[i].exp);
            end
        end

        // Random phases, each with its own register setting.
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            v_low   = (p == 0) ? '0 : (p == 1) ? '1 :
                      ($urandom_range(1) ? bpsc_pkg::LOW_THRESHOLD_RST : $urandom);
            v_rec   = (p % 3 == 2);
            v_rthr  = (p == 2) ? '0 : (p == 5) ? '1 : $urandom;
            v_first = (p == 0) ? 16'd1 : (p == 1) ? 16'hFFFF : 16'($urandom_range(65535, 1));
            // short timeouts so critical runs out often; one phase each of
            // the longest, the shortest and the out-of-range zero
            v_run   = (p == 1) ? 16'hFFFF : (p == 3) ? 16'd1 : (p == 4) ? 16'd0 :
                      16'($urandom_range(12, 1));
            push_reg(bpsc_pkg::CFG_LOW_THRESHOLD, v_low);
            push_reg(bpsc_pkg::CFG_RECOVERY_MODE, {31'b0, v_rec});
            push_reg(bpsc_pkg::CFG_RECOVERY_THRES, v_rthr);
            push_reg(bpsc_pkg::CFG_FIRST_TIMEOUT, {16'b0, v_first});
            push_reg(bpsc_pkg::CFG_RUN_TIMEOUT, {16'b0, v_run});
            cfg_valid <= 1'b0;

            if (p == 3)
                hold_token <= ~hold_token;     // receiver stalls, sender keeps going
            no_idle <= (p == 6);

            n = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(99) < 8) begin
                    // drive into critical, then tick it out
                    it.req_type           = bpsc_pkg::REQ_EVENT;
                    it.charge_ratio       = '0;
                    it.charging           = 1'b0;
                    it.ext_power          = 1'b0;
                    it.update_in_progress = $urandom_range(1);
                    send_item(it, 1'b0, '0);
                    burst = (pwr_cfg.running_timeout > 16) ? 17 : pwr_cfg.running_timeout + 1;
                    for (int k = 0; k < burst; k++) begin
                        it.req_type     = bpsc_pkg::REQ_TICK;
                        it.charge_ratio = $urandom;
                        send_item(it, 1'b0, '0);
                    end
                    n += burst + 1;
                end else begin
                    it.req_type           = ($urandom_range(99) < 40) ? bpsc_pkg::REQ_TICK
                                                                      : bpsc_pkg::REQ_EVENT;
                    it.charge_ratio       = pick_charge();
                    it.charging           = ($urandom_range(99) < 25);
                    it.ext_power          = ($urandom_range(99) < 20);
                    it.update_in_progress = ($urandom_range(99) < 30);
                    send_item(it, 1'b0, '0);
                    n++;
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_modes.size() != 0)
            note_error("result never arrived", expected_modes[0], '0);

        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
